>>> design/escd_pkg.sv
// ----------------------------------------------------------------------------
// escd_pkg: shared types and codes of the escape sequence decoder
// Result status codes and the result group that travels from the decoder
// to the output stage of the top level.
// ----------------------------------------------------------------------------
package escd_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_DIGITS  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE   = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  // All results of one escape: up to four bytes, lowest entry first
  typedef struct packed {
    logic [3:0][7:0] bytes;     // result bytes, entry 0 goes out first
    logic [1:0]      last_idx;  // index of the final byte (count - 1)
    logic [1:0]      status;    // status shared by the whole group
  } grp_t;

endpackage

>>> design/escd_decode.sv
// ----------------------------------------------------------------------------
// escd_decode: escape body state and result group builder
// Holds the escape class, counters and digit accumulator. On the final
// character it builds the whole result group in one pass and clears state.
// ----------------------------------------------------------------------------
module escd_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,     // a character transfer this cycle
  input  logic [7:0]          ch,
  input  logic                fin,      // final character of the escape body
  output escd_pkg::grp_t      grp       // results, meaningful when fire && fin
);

  // Escape classes
  localparam logic [2:0] CLS_WAIT  = 3'd0;
  localparam logic [2:0] CLS_NAMED = 3'd1;
  localparam logic [2:0] CLS_OCT   = 3'd2;
  localparam logic [2:0] CLS_HEX2  = 3'd3;
  localparam logic [2:0] CLS_HEX4  = 3'd4;
  localparam logic [2:0] CLS_HEX8  = 3'd5;
  localparam logic [2:0] CLS_BAD   = 3'd6;

  localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

  // Map a named escape letter to its byte; bit 8 flags a hit
  function automatic logic [8:0] named_lookup(input logic [7:0] c);
    logic [8:0] r;
    begin
      r = 9'h000;
      unique case (c)
        8'h61:   r = {1'b1, 8'h07};  // a
        8'h62:   r = {1'b1, 8'h08};  // b
        8'h65:   r = {1'b1, 8'h1B};  // e
        8'h66:   r = {1'b1, 8'h0C};  // f
        8'h6E:   r = {1'b1, 8'h0A};  // n
        8'h72:   r = {1'b1, 8'h0D};  // r
        8'h74:   r = {1'b1, 8'h09};  // t
        8'h76:   r = {1'b1, 8'h0B};  // v
        8'h5C:   r = {1'b1, 8'h5C};  // backslash
        8'h27:   r = {1'b1, 8'h27};  // single quote
        8'h22:   r = {1'b1, 8'h22};  // double quote
        8'h3F:   r = {1'b1, 8'h3F};  // question mark
        default: r = 9'h000;
      endcase
      return r;
    end
  endfunction

  // Hex digit value; bit 4 flags a valid digit
  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
        return {1'b1, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
        return {1'b1, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
        return {1'b1, d[3:0]};
      end
      return 5'h00;
    end
  endfunction

  // Number of hex digits each hex class takes
  function automatic logic [3:0] need_of(input logic [2:0] cls);
    begin
      if (cls == CLS_HEX2) begin
        return 4'd2;
      end else if (cls == CLS_HEX4) begin
        return 4'd4;
      end
      return 4'd8;
    end
  endfunction

  logic [2:0]  cls_r,    cls_nxt;
  logic [3:0]  cnt_r,    cnt_nxt;
  logic [31:0] acc_r,    acc_nxt;
  logic [3:0]  taken_r,  taken_nxt;
  logic        ostop_r,  ostop_nxt;
  logic        derr_r,   derr_nxt;
  logic [7:0]  simple_r, simple_nxt;

  logic [8:0]  named;
  logic [4:0]  hexd;
  logic        is_oct;
  logic        is_hex_cls;
  logic [3:0]  need_cur;
  logic [3:0]  need_nxt;
  logic [20:0] cp;

  assign named      = named_lookup(ch);
  assign hexd       = hex_lookup(ch);
  assign is_oct     = (ch >= 8'h30) && (ch <= 8'h37);
  assign is_hex_cls = (cls_r == CLS_HEX2) || (cls_r == CLS_HEX4) || (cls_r == CLS_HEX8);
  assign need_cur   = need_of(cls_r);
  assign need_nxt   = need_of(cls_nxt);
  assign cp         = acc_nxt[20:0];

  // Advance the escape state by one character
  always_comb begin
    cls_nxt    = cls_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    taken_nxt  = taken_r;
    ostop_nxt  = ostop_r;
    derr_nxt   = derr_r;
    simple_nxt = simple_r;
    if (cls_r == CLS_WAIT) begin
      cnt_nxt    = 4'd0;
      acc_nxt    = 32'd0;
      taken_nxt  = 4'd0;
      ostop_nxt  = 1'b0;
      derr_nxt   = 1'b0;
      simple_nxt = 8'h00;
      priority if (named[8]) begin
        cls_nxt    = CLS_NAMED;
        simple_nxt = named[7:0];
      end else if (is_oct) begin
        cls_nxt   = CLS_OCT;
        acc_nxt   = {29'd0, ch[2:0]};
        taken_nxt = 4'd1;
      end else if (ch == 8'h78) begin
        cls_nxt = CLS_HEX2;
      end else if (ch == 8'h75) begin
        cls_nxt = CLS_HEX4;
      end else if (ch == 8'h55) begin
        cls_nxt = CLS_HEX8;
      end else begin
        cls_nxt = CLS_BAD;
      end
    end else begin
      if (cls_r == CLS_OCT) begin
        if (!ostop_r && taken_r < 4'd3) begin
          if (is_oct) begin
            acc_nxt   = {acc_r[28:0], ch[2:0]};
            taken_nxt = taken_r + 4'd1;
          end else begin
            ostop_nxt = 1'b1;
          end
        end
      end else if (is_hex_cls) begin
        if (cnt_r < need_cur) begin
          if (hexd[4]) begin
            acc_nxt   = {acc_r[27:0], hexd[3:0]};
            taken_nxt = taken_r + 4'd1;
          end else begin
            derr_nxt = 1'b1;
          end
        end
      end
      if (cnt_r != 4'hF) begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  // Build the result group from the updated state
  always_comb begin
    grp.bytes    = '0;
    grp.last_idx = 2'd0;
    grp.status   = escd_pkg::ST_OK;
    unique case (cls_nxt)
      CLS_NAMED: begin
        grp.bytes[0] = simple_nxt;
      end
      CLS_OCT: begin
        grp.bytes[0] = acc_nxt[7:0];
      end
      CLS_HEX2, CLS_HEX4, CLS_HEX8: begin
        priority if (derr_nxt || taken_nxt != need_nxt) begin
          grp.status = escd_pkg::ST_BAD_DIGITS;
        end else if (cls_nxt == CLS_HEX2) begin
          grp.bytes[0] = acc_nxt[7:0];
        end else if (acc_nxt > MAX_CODE_POINT) begin
          grp.status = escd_pkg::ST_TOO_LARGE;
        end else if (cp < 21'h80) begin
          grp.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
          grp.bytes[0]  = {3'b110, cp[10:6]};
          grp.bytes[1]  = {2'b10, cp[5:0]};
          grp.last_idx  = 2'd1;
        end else if (cp < 21'h10000) begin
          grp.bytes[0]  = {4'b1110, cp[15:12]};
          grp.bytes[1]  = {2'b10, cp[11:6]};
          grp.bytes[2]  = {2'b10, cp[5:0]};
          grp.last_idx  = 2'd2;
        end else begin
          grp.bytes[0]  = {5'b11110, cp[20:18]};
          grp.bytes[1]  = {2'b10, cp[17:12]};
          grp.bytes[2]  = {2'b10, cp[11:6]};
          grp.bytes[3]  = {2'b10, cp[5:0]};
          grp.last_idx  = 2'd3;
        end
      end
      default: begin
        grp.status = escd_pkg::ST_UNSUPPORTED;
      end
    endcase
  end

  // Hold state between characters; clear after the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r    <= CLS_WAIT;
      cnt_r    <= 4'd0;
      acc_r    <= 32'd0;
      taken_r  <= 4'd0;
      ostop_r  <= 1'b0;
      derr_r   <= 1'b0;
      simple_r <= 8'h00;
    end else if (fire) begin
      if (fin) begin
        cls_r    <= CLS_WAIT;
        cnt_r    <= 4'd0;
        acc_r    <= 32'd0;
        taken_r  <= 4'd0;
        ostop_r  <= 1'b0;
        derr_r   <= 1'b0;
        simple_r <= 8'h00;
      end else begin
        cls_r    <= cls_nxt;
        cnt_r    <= cnt_nxt;
        acc_r    <= acc_nxt;
        taken_r  <= taken_nxt;
        ostop_r  <= ostop_nxt;
        derr_r   <= derr_nxt;
        simple_r <= simple_nxt;
      end
    end
  end

endmodule

>>> design/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder: C style escape body to bytes / UTF-8
// Takes the characters after the backslash one per transfer and emits the
// decoded bytes, or one error result, after the final character.
// ----------------------------------------------------------------------------
//
//  Channel | Ports  | tdata          | tuser       | tlast
//  --------+--------+----------------+-------------+-----------------------
//  input   | in_*   | [7:0] ch       | -           | end_of_escape
//  result  | out_*  | [7:0] out_byte | [1:0] status| last_byte
//
//  One character is taken per cycle while in_tready is high; a final
//  character produces its whole result group (1 to 4 bytes) in the same
//  cycle, and the output stage sends one byte per cycle while out_tready
//  is high. A one-entry skid register keeps in_tready a plain register
//  output. Reset leaves both stages empty and the decoder waiting for an
//  escape letter. A stall on the result side fills the skid register,
//  after which in_tready drops.
//
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);

  escd_pkg::grp_t  new_grp;
  logic            in_fire;
  logic            new_valid;
  logic            out_fire;
  logic            b_free;

  // Skid register
  logic            a_full_r,   a_full_nxt;
  escd_pkg::grp_t  a_grp_r,    a_grp_nxt;

  // Output register
  logic            b_valid_r,  b_valid_nxt;
  logic [3:0][7:0] b_bytes_r,  b_bytes_nxt;
  logic [1:0]      b_left_r,   b_left_nxt;
  logic [1:0]      b_status_r, b_status_nxt;

  assign in_tready = !a_full_r;
  assign in_fire   = in_tvalid && in_tready;
  assign new_valid = in_fire && in_tlast;
  assign out_fire  = out_tvalid && out_tready;
  assign b_free    = !b_valid_r || (out_tready && b_left_r == 2'd0);

  escd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .ch    (in_tdata),
    .fin   (in_tlast),
    .grp   (new_grp)
  );

  // Route result groups through the skid and output registers
  always_comb begin
    a_full_nxt   = a_full_r;
    a_grp_nxt    = a_grp_r;
    b_valid_nxt  = b_valid_r;
    b_bytes_nxt  = b_bytes_r;
    b_left_nxt   = b_left_r;
    b_status_nxt = b_status_r;
    if (b_free) begin
      priority if (a_full_r) begin
        b_valid_nxt  = 1'b1;
        b_bytes_nxt  = a_grp_r.bytes;
        b_left_nxt   = a_grp_r.last_idx;
        b_status_nxt = a_grp_r.status;
        a_full_nxt   = 1'b0;
      end else if (new_valid) begin
        b_valid_nxt  = 1'b1;
        b_bytes_nxt  = new_grp.bytes;
        b_left_nxt   = new_grp.last_idx;
        b_status_nxt = new_grp.status;
      end else begin
        b_valid_nxt  = 1'b0;
      end
    end else begin
      if (out_fire) begin
        b_bytes_nxt = {8'h00, b_bytes_r[3], b_bytes_r[2], b_bytes_r[1]};
        b_left_nxt  = b_left_r - 2'd1;
      end
      if (new_valid) begin
        a_full_nxt = 1'b1;
        a_grp_nxt  = new_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_full_r  <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_full_r  <= a_full_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_grp_r    <= a_grp_nxt;
    b_bytes_r  <= b_bytes_nxt;
    b_left_r   <= b_left_nxt;
    b_status_r <= b_status_nxt;
  end

  // Drive the result channel from the output register
  assign out_tvalid = b_valid_r;
  assign out_tdata  = b_bytes_r[0];
  assign out_tuser  = b_status_r;
  assign out_tlast  = (b_left_r == 2'd0);

  // Skid register fills only behind a busy output register
  a_full_needs_b : assert property (@(posedge clk) disable iff (!rst_n)
    a_full_r |-> b_valid_r)
    else $error("skid register full while output register empty");

  // Error results are single zero bytes
  err_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != escd_pkg::ST_OK) |-> (out_tlast && out_tdata == 8'h00))
    else $error("error result not a single zero byte");

  // A multi-byte group carries on after a non-final transfer
  group_continues : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("result group cut short");

  // Status stays the same across the bytes of one group
  status_steady : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> $stable(out_tuser))
    else $error("status changed inside a result group");

endmodule
